// ===== rtl/sbsm_pkg.sv =====
// Shared types and constants for the serial bank-switch mapper.
// No dependencies; used by every module of the block.
package sbsm_pkg;

    // Target register picked by address bits 14:13 on the fifth serial bit
    localparam logic [1:0] TGT_CONTROL  = 2'd0;
    localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
    localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
    localparam logic [1:0] TGT_PRG      = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    localparam logic [4:0] CONTROL_RESET = 5'h0C;
    localparam logic [4:0] CONTROL_MODE  = 5'h0C;
    localparam logic [4:0] EVEN_MASK     = 5'h1E;
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;
    localparam logic [1:0] MIRROR_VERTICAL    = 2'd2;
    localparam logic [2:0] SERIAL_BITS        = 3'd5;

    localparam int PRG_COUNT_W = 6;
    localparam int CHR_COUNT_W = 8;
    localparam int CFG_DATA_W  = 8;

    typedef struct packed {
        logic [4:0] control;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [4:0] prg;
    } bank_state_t;

    typedef struct packed {
        logic       start;
        logic [4:0] dividend;
        logic [7:0] divisor;
    } mod_req_t;

endpackage

// ===== rtl/sbsm_serial.sv =====
// Serial shifter and bank select registers of the mapper.
// Depends on sbsm_pkg.
module sbsm_serial
    import sbsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [15:0] cpu_address,
    input  logic [7:0]  write_data,
    output bank_state_t bank_state
);

    logic [4:0]  shifter_reg, shifter_next;
    logic [2:0]  count_reg, count_next;
    bank_state_t regs_reg, regs_next;
    logic [4:0]  shifted;
    logic [2:0]  count_inc;

    always_comb
    begin
        shifted      = shifter_reg | (5'(write_data[0]) << count_reg);
        count_inc    = count_reg + 3'd1;
        shifter_next = shifter_reg;
        count_next   = count_reg;
        regs_next    = regs_reg;
        if (load && cpu_address[15])
        begin
            if (write_data[7])
            begin
                shifter_next      = '0;
                count_next        = '0;
                regs_next.control = regs_reg.control | CONTROL_MODE;
            end
            else if (count_inc >= SERIAL_BITS)
            begin
                shifter_next = '0;
                count_next   = '0;
                case (cpu_address[14:13])
                    TGT_CONTROL:  regs_next.control  = shifted;
                    TGT_CHR_LOW:  regs_next.chr_low  = shifted;
                    TGT_CHR_HIGH: regs_next.chr_high = shifted;
                    TGT_PRG:      regs_next.prg      = shifted;
                    default:      regs_next.prg      = shifted;
                endcase
            end
            else
            begin
                shifter_next = shifted;
                count_next   = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shifter_reg       <= '0;
            count_reg         <= '0;
            regs_reg.control  <= CONTROL_RESET;
            regs_reg.chr_low  <= '0;
            regs_reg.chr_high <= '0;
            regs_reg.prg      <= '0;
        end
        else
        begin
            shifter_reg <= shifter_next;
            count_reg   <= count_next;
            regs_reg    <= regs_next;
        end
    end

    assign bank_state = regs_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < SERIAL_BITS)
        else $error("serial bit count out of range");
`endif

endmodule

// ===== rtl/sbsm_mod.sv =====
// Shared modulo unit: 5-bit dividend mod 8-bit divisor, one restoring
// compare/subtract step per cycle. Depends on sbsm_pkg.
module sbsm_mod
    import sbsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mod_req_t   req,
    output logic       done,
    output logic [4:0] result
);

    logic [4:0]  rem_reg, rem_next;
    logic [7:0]  div_reg, div_next;
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [11:0] div_shifted;
    logic        take;

    always_comb
    begin
        div_shifted = {4'b0, div_reg} << step_reg;
        take        = {7'b0, rem_reg} >= div_shifted;
        rem_next    = rem_reg;
        div_next    = div_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            div_next  = req.divisor;
            step_next = 3'd4;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (take)
                rem_next = rem_reg - div_shifted[4:0];
            if (step_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("modulo unit started while busy");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (div_reg != 8'd0) |-> ({3'b0, rem_reg} < div_reg))
        else $error("modulo result not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("done without a running reduction");
`endif

endmodule

// ===== rtl/serial_bank_switch_mapper.sv =====
// Top level of the serial bank-switch mapper: handshakes, config registers,
// sequencer and result register. Depends on sbsm_pkg, sbsm_serial, sbsm_mod.
//
// Each accepted CPU write updates the serial shifter and bank selects at the
// transfer, then four bank numbers are reduced modulo the configured bank
// counts one after another on a single shared modulo unit (five restoring
// steps each, plus issue and collect). The result is registered once all four
// are collected, and the next write is not taken until the sequencer is idle
// again; in_ready is low while the reduction runs. A finished result that is
// not yet taken holds the sequencer until the output register frees.
module serial_bank_switch_mapper
    import sbsm_pkg::*;
#(
    parameter int PRG_BANKS_MAX = 32,
    parameter int CHR_BANKS_MAX = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [15:0]           cpu_address,
    input  logic [7:0]            write_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [4:0]            prg_low_bank,
    output logic [4:0]            prg_high_bank,
    output logic [6:0]            chr_low_bank,
    output logic [6:0]            chr_high_bank,
    output logic                  vertical_mirror
);

    localparam logic [PRG_COUNT_W-1:0] PRG_MAX = PRG_COUNT_W'(PRG_BANKS_MAX);
    localparam logic [CHR_COUNT_W-1:0] CHR_MAX = CHR_COUNT_W'(CHR_BANKS_MAX);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [PRG_COUNT_W-1:0] prg_count_reg;
    logic [CHR_COUNT_W-1:0] chr_count_reg;
    logic [1:0]             state_reg, state_next;
    logic [1:0]             op_reg, op_next;
    logic [4:0]             res_reg [4];
    logic                   out_valid_reg, out_valid_next;
    logic [4:0]             prg_low_reg, prg_high_reg;
    logic [6:0]             chr_low_reg, chr_high_reg;
    logic                   mirror_reg;

    logic                   accept;
    logic                   load_out;
    bank_state_t            bank_state;
    mod_req_t               mod_req;
    logic                   mod_done;
    logic [4:0]             mod_result;
    logic [PRG_COUNT_W-1:0] prg_n;
    logic [CHR_COUNT_W-1:0] chr_m;
    logic [4:0]             prg_even, chr_even;
    logic [1:0]             prg_mode;
    logic [4:0]             lo_val, hi_val;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= PRG_COUNT_W'(2);
            chr_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PRG_COUNT: prg_count_reg <= cfg_data[PRG_COUNT_W-1:0];
                CFG_CHR_COUNT: chr_count_reg <= cfg_data[CHR_COUNT_W-1:0];
                default:       prg_count_reg <= prg_count_reg;
            endcase
        end
    end

    sbsm_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .cpu_address (cpu_address),
        .write_data  (write_data),
        .bank_state  (bank_state)
    );

    assign prg_n    = (prg_count_reg > PRG_MAX) ? PRG_MAX : prg_count_reg;
    assign chr_m    = (chr_count_reg > CHR_MAX) ? CHR_MAX : chr_count_reg;
    assign prg_even = bank_state.prg & EVEN_MASK;
    assign chr_even = bank_state.chr_low & EVEN_MASK;
    assign prg_mode = bank_state.control[3:2];

    // Operand for each reduction; 32K / 8K modes use the even/odd pair
    always_comb
    begin
        mod_req.start = (state_reg == ST_ISSUE);
        case (op_reg)
            2'd0:
            begin
                mod_req.dividend = bank_state.control[3] ? bank_state.prg : prg_even;
                mod_req.divisor  = CHR_COUNT_W'(prg_n);
            end
            2'd1:
            begin
                mod_req.dividend = bank_state.control[3] ? bank_state.prg
                                                         : (prg_even | 5'd1);
                mod_req.divisor  = CHR_COUNT_W'(prg_n);
            end
            2'd2:
            begin
                mod_req.dividend = bank_state.control[4] ? bank_state.chr_low : chr_even;
                mod_req.divisor  = chr_m;
            end
            default:
            begin
                mod_req.dividend = bank_state.control[4] ? bank_state.chr_high
                                                         : (chr_even | 5'd1);
                mod_req.divisor  = chr_m;
            end
        endcase
    end

    sbsm_mod u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mod_req),
        .done   (mod_done),
        .result (mod_result)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && mod_done)
            res_reg[op_reg] <= mod_result;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ISSUE;
                    op_next    = 2'd0;
                end
            end
            ST_ISSUE:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (mod_done)
                begin
                    if (op_reg == 2'd3)
                        state_next = ST_FINISH;
                    else
                    begin
                        op_next    = op_reg + 2'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // First-fixed mode pins the low slot to bank 0, last-fixed pins high to n-1
    assign lo_val = (prg_mode == PRG_MODE_FIX_FIRST) ? 5'd0 : res_reg[0];
    assign hi_val = (prg_mode == PRG_MODE_FIX_LAST) ? 5'(prg_n - PRG_COUNT_W'(1))
                                                    : res_reg[1];

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (prg_n == '0)
            begin
                prg_low_reg  <= '0;
                prg_high_reg <= '0;
                chr_low_reg  <= '0;
                chr_high_reg <= '0;
                mirror_reg   <= 1'b0;
            end
            else
            begin
                prg_low_reg  <= lo_val;
                prg_high_reg <= hi_val;
                chr_low_reg  <= (chr_m == '0) ? 7'd0 : 7'(res_reg[2]);
                chr_high_reg <= (chr_m == '0) ? 7'd0 : 7'(res_reg[3]);
                mirror_reg   <= (bank_state.control[1:0] == MIRROR_VERTICAL);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign prg_low_bank    = prg_low_reg;
    assign prg_high_bank   = prg_high_reg;
    assign chr_low_bank    = chr_low_reg;
    assign chr_high_bank   = chr_high_reg;
    assign vertical_mirror = mirror_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ISSUE) && (op_reg == 2'd0))
        else $error("transfer did not start the reduction sequence");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_valid_reg && !out_ready
            |=> (state_reg == ST_FINISH) && out_valid_reg)
        else $error("pending result overwritten");
`endif

endmodule

// ===== test/serial_bank_switch_mapper_tb.sv =====
// Self-checking testbench for serial_bank_switch_mapper: serial register loads,
// resets, ignored writes and bank-count settings, checked against an in-bench predictor.
// Depends on sbsm_pkg and the serial_bank_switch_mapper RTL.
module serial_bank_switch_mapper_tb;
    import sbsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PRG_MAX         = 32;
    localparam int          CHR_MAX         = 128;
    localparam logic [15:0] MAPPER_BASE     = 16'h8000;
    localparam int          RESET_BIT       = 7;
    localparam int          CTRL_PRG_FIXED  = 3;    // 0: 32K switching
    localparam int          CTRL_CHR_4K     = 4;
    localparam logic [5:0]  PRG_COUNT_RESET = 6'd2;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          TAIL_CYCLES     = 40;
    localparam int          CYCLE_LIMIT     = 600_000;

    typedef struct packed {
        logic [4:0] prg_lo;
        logic [4:0] prg_hi;
        logic [6:0] chr_lo;
        logic [6:0] chr_hi;
        logic       mirror;
    } bank_map_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [15:0]           cpu_address;
    logic [7:0]            write_data;
    logic                  out_valid;
    logic                  out_ready;
    logic [4:0]            prg_low_bank;
    logic [4:0]            prg_high_bank;
    logic [6:0]            chr_low_bank;
    logic [6:0]            chr_high_bank;
    logic                  vertical_mirror;

    // predictor state
    bank_state_t            bank_sel;
    logic [4:0]             shift_reg;
    logic [2:0]             shift_count;
    logic [PRG_COUNT_W-1:0] prg_count;
    logic [CHR_COUNT_W-1:0] chr_count;

    bank_map_t expected_maps[$];

    bit sender_idles    = 1'b1;
    bit receiver_stalls = 1'b1;
    int hold_cycles     = 0;
    int stall_left      = 0;
    int writes_sent     = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    serial_bank_switch_mapper #(
        .PRG_BANKS_MAX(PRG_MAX),
        .CHR_BANKS_MAX(CHR_MAX)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cpu_address    (cpu_address),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prg_low_bank   (prg_low_bank),
        .prg_high_bank  (prg_high_bank),
        .chr_low_bank   (chr_low_bank),
        .chr_high_bank  (chr_high_bank),
        .vertical_mirror(vertical_mirror)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_maps.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Applies one CPU write to the predicted mapper state, returns the mapping after it.
    function automatic bank_map_t predict_write(input logic [15:0] addr,
                                                input logic [7:0]  data);
        bank_map_t   banks;
        int unsigned n;
        int unsigned m;
        banks = '0;
        if (addr >= MAPPER_BASE)
        begin
            if (data[RESET_BIT])
            begin
                shift_reg        = '0;
                shift_count      = '0;
                bank_sel.control = bank_sel.control | CONTROL_MODE;
            end
            else
            begin
                shift_reg[shift_count] = data[0];
                shift_count++;
                if (shift_count == SERIAL_BITS)
                begin
                    case (addr[14:13])
                        TGT_CONTROL:  bank_sel.control  = shift_reg;
                        TGT_CHR_LOW:  bank_sel.chr_low  = shift_reg;
                        TGT_CHR_HIGH: bank_sel.chr_high = shift_reg;
                        TGT_PRG:      bank_sel.prg      = shift_reg;
                        default:      bank_sel.prg      = shift_reg;
                    endcase
                    shift_reg   = '0;
                    shift_count = '0;
                end
            end
        end

        n = (prg_count > PRG_MAX) ? PRG_MAX : 32'(prg_count);
        m = (chr_count > CHR_MAX) ? CHR_MAX : 32'(chr_count);
        if (n != 0)
        begin
            banks.mirror = (bank_sel.control[1:0] == MIRROR_VERTICAL);
            if (!bank_sel.control[CTRL_PRG_FIXED])
            begin
                banks.prg_lo = 5'((bank_sel.prg & EVEN_MASK) % n);
                banks.prg_hi = 5'(((bank_sel.prg & EVEN_MASK) | 5'd1) % n);
            end
            else if (bank_sel.control[3:2] == PRG_MODE_FIX_FIRST)
            begin
                banks.prg_lo = '0;
                banks.prg_hi = 5'(bank_sel.prg % n);
            end
            else
            begin
                banks.prg_lo = 5'(bank_sel.prg % n);
                banks.prg_hi = 5'(n - 1);
            end
            if (m != 0)
            begin
                if (!bank_sel.control[CTRL_CHR_4K])
                begin
                    banks.chr_lo = 7'((bank_sel.chr_low & EVEN_MASK) % m);
                    banks.chr_hi = 7'(((bank_sel.chr_low & EVEN_MASK) | 5'd1) % m);
                end
                else
                begin
                    banks.chr_lo = 7'(bank_sel.chr_low % m);
                    banks.chr_hi = 7'(bank_sel.chr_high % m);
                end
            end
        end
        return banks;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_result
        bank_map_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_maps.size() == 0)
                report_mismatch("result transfer with no write pending", 1, 0);
            else
            begin
                want = expected_maps.pop_front();
                results_checked++;
                if (prg_low_bank !== want.prg_lo)
                    report_mismatch("prg_low_bank", int'(prg_low_bank),
                                    int'(want.prg_lo));
                if (prg_high_bank !== want.prg_hi)
                    report_mismatch("prg_high_bank", int'(prg_high_bank),
                                    int'(want.prg_hi));
                if (chr_low_bank !== want.chr_lo)
                    report_mismatch("chr_low_bank", int'(chr_low_bank),
                                    int'(want.chr_lo));
                if (chr_high_bank !== want.chr_hi)
                    report_mismatch("chr_high_bank", int'(chr_high_bank),
                                    int'(want.chr_hi));
                if (vertical_mirror !== want.mirror)
                    report_mismatch("vertical_mirror", int'(vertical_mirror),
                                    int'(want.mirror));
            end
        end
    end

    // Output side: long holds on request, otherwise random stall bursts.
    initial
    begin : receiver
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Valid stays high from one transfer to the next unless an idle burst is taken.
    task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cpu_address <= addr;
        write_data  <= data;
        do
            @(posedge clk);
        while (!in_ready);
        expected_maps.push_back(predict_write(addr, data));
        writes_sent++;
    endtask

    task automatic load_register(input logic [1:0] target, input logic [4:0] value,
                                 input logic [12:0] offset);
        logic [7:0] data;
        for (int b = 0; b < 5; b++)
        begin
            data    = 8'($urandom_range(0, 127));
            data[0] = value[b];
            send_write({1'b1, target, offset}, data);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_maps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both count registers back to back; block must be idle.
    task automatic set_counts(input logic [7:0] prg, input logic [7:0] chr);
        cfg_write <= 1'b1;
        cfg_index <= CFG_PRG_COUNT;
        cfg_data  <= prg;
        @(posedge clk);
        prg_count = prg[PRG_COUNT_W-1:0];
        cfg_index <= CFG_CHR_COUNT;
        cfg_data  <= chr;
        @(posedge clk);
        chr_count = chr;
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Mostly complete five-bit loads; some resets, broken loads and ignored writes.
    task automatic random_traffic(input int count);
        int         sent;
        int         pick;
        int         partial;
        logic [7:0] data;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                load_register(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                              13'($urandom_range(0, 16'h1FFF)));
                sent += 5;
            end
            else if (pick < 87)
            begin
                data = 8'($urandom_range(128, 255));
                send_write(16'($urandom_range(16'h8000, 16'hFFFF)), data);
                sent++;
            end
            else if (pick < 94)
                send_write(16'($urandom_range(0, 16'h7FFF)), 8'($urandom_range(0, 255)));
            else
            begin
                // partial load, then either a reset byte or an ignored write in the middle
                partial = $urandom_range(1, 4);
                repeat (partial)
                begin
                    data = 8'($urandom_range(0, 127));
                    send_write(16'($urandom_range(16'h8000, 16'hFFFF)), data);
                end
                if ($urandom_range(0, 1))
                    send_write(16'($urandom_range(16'h8000, 16'hFFFF)),
                               8'($urandom_range(128, 255)));
                else
                    send_write(16'($urandom_range(0, 16'h7FFF)),
                               8'($urandom_range(0, 255)));
                sent += partial + 1;
            end
        end
    endtask

    task automatic test_ignored_writes();
        send_write(16'h0000, 8'hFF);
        send_write(16'h7FFF, 8'h80);
        send_write(16'h2AAA, 8'h01);
    endtask

    task automatic test_directed_loads();
        settle();
        set_counts(8'(PRG_MAX), 8'(CHR_MAX));
        load_register(TGT_CONTROL, 5'h1F, 13'h0000);
        load_register(TGT_CHR_LOW, 5'h15, 13'h1FFF);
        load_register(TGT_CHR_HIGH, 5'h1F, 13'h0000);
        load_register(TGT_PRG, 5'h1F, 13'h1FFF);
        send_write(16'hE000, 8'hFF);
        send_write(16'hFFFF, 8'h01);
        send_write(16'h8000, 8'h7E);
        send_write(16'h8000, 8'h80);
    endtask

    task automatic test_config_sweep();
        logic [7:0] prg_set [9] = '{8'd2, 8'd0, 8'd32, 8'd1, 8'd63, 8'd33, 8'd3,
                                    8'd0, 8'd0};
        logic [7:0] chr_set [9] = '{8'd0, 8'd128, 8'd128, 8'd1, 8'd255, 8'd129, 8'd2,
                                    8'd0, 8'd0};
        prg_set[7] = 8'($urandom_range(0, 63));
        chr_set[7] = 8'($urandom_range(0, 255));
        prg_set[8] = 8'($urandom_range(2, 31));
        chr_set[8] = 8'($urandom_range(2, 127));
        for (int i = 0; i < 9; i++)
        begin
            settle();
            set_counts(prg_set[i], chr_set[i]);
            random_traffic(115);
        end
    endtask

    task automatic test_output_backpressure();
        settle();
        set_counts(8'(PRG_MAX), 8'(CHR_MAX));
        sender_idles = 1'b0;
        hold_cycles  = 300;
        random_traffic(30);
        sender_idles = 1'b1;
    endtask

    task automatic test_drain_pause();
        random_traffic(20);
        settle();
        random_traffic(20);
    endtask

    task automatic test_unthrottled();
        settle();
        set_counts(8'($urandom_range(1, 32)), 8'($urandom_range(1, 128)));
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        random_traffic(150);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= CFG_PRG_COUNT;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        cpu_address <= '0;
        write_data  <= '0;
        bank_sel         = '0;
        bank_sel.control = CONTROL_RESET;
        shift_reg        = '0;
        shift_count      = '0;
        prg_count        = PRG_COUNT_RESET;
        chr_count        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_writes();
        test_directed_loads();
        test_config_sweep();
        test_output_backpressure();
        test_drain_pause();
        test_unthrottled();

        in_valid <= 1'b0;
        while (expected_maps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_maps.size() != 0)
            report_mismatch("results never delivered", 0, expected_maps.size());

        $display("Ran %0d CPU writes, %0d mappings checked, %0d bank-count settings",
                 writes_sent, results_checked, settings_used);
        $display("Included resets, broken loads, ignored writes, long output hold");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sbsm_pkg.sv
rtl/sbsm_serial.sv
rtl/sbsm_mod.sv
rtl/serial_bank_switch_mapper.sv
test/serial_bank_switch_mapper_tb.sv
